// File: hdl/etq_pkg.sv
package etq_pkg;

    // default field widths
    localparam int ANGLE_BITS_DEF = 16;
    localparam int COMP_BITS_DEF  = 16;

    // cordic datapath
    localparam int CORDIC_STEPS = 30;
    localparam int XY_W         = 34;   // q2.30 with growth headroom
    localparam int Z_W          = 33;   // 32-bit binary angle plus headroom
    localparam int SC_W         = 32;   // sine and cosine after the last step
    localparam int PAIR_SHIFT   = 30;
    localparam int PROD_W       = 64;

    localparam logic signed [XY_W-1:0] CORDIC_START = 34'sd652032874;

    // arctangent of 2^-i as a 32-bit binary angle
    localparam logic signed [Z_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756, 33'sd42667331,
        33'sd21354465,  33'sd10679838,  33'sd5340245,   33'sd2670163,  33'sd1335087,
        33'sd667544,    33'sd333772,    33'sd166886,    33'sd83443,    33'sd41722,
        33'sd20861,     33'sd10430,     33'sd5215,      33'sd2608,     33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81,       33'sd41,
        33'sd20,        33'sd10,        33'sd5,         33'sd3,        33'sd1
    };

    // one rotation lane: cosine, sine and residual angle
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_lane;

    typedef t_lane [2:0] t_lanes;

    // sine and cosine of one half angle
    typedef struct packed {
        logic signed [SC_W-1:0] c;
        logic signed [SC_W-1:0] s;
    } t_sc;

    typedef t_sc [2:0] t_sc3;

    // product of two q2.30 values back in q2.30, floor shift
    function automatic logic signed [SC_W-1:0] pair_mul(
        input logic signed [SC_W-1:0] a,
        input logic signed [SC_W-1:0] b
    );
        logic signed [PROD_W-1:0] p;
        p = a * b;
        return SC_W'(p >>> PAIR_SHIFT);
    endfunction

endpackage

// File: hdl/etq_cordic_stage.sv
module etq_cordic_stage import etq_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    output logic   o_rdy,
    input  t_lanes i_lanes,
    output logic   o_vld,
    input  logic   i_rdy,
    output t_lanes o_lanes
);

    logic   r_vld;
    t_lanes r_lanes;
    t_lanes n_lanes;

    // stage can load when empty or when its beat moves on
    assign o_rdy = !r_vld || i_rdy;

    // one rotation step on all three lanes
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (i_lanes[l].z >= 0) begin
                n_lanes[l].x = i_lanes[l].x - (i_lanes[l].y >>> STEP);
                n_lanes[l].y = i_lanes[l].y + (i_lanes[l].x >>> STEP);
                n_lanes[l].z = i_lanes[l].z - ATAN_TURN[STEP];
            end else begin
                n_lanes[l].x = i_lanes[l].x + (i_lanes[l].y >>> STEP);
                n_lanes[l].y = i_lanes[l].y - (i_lanes[l].x >>> STEP);
                n_lanes[l].z = i_lanes[l].z + ATAN_TURN[STEP];
            end
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_lanes <= n_lanes;
        end
    end

    assign o_vld   = r_vld;
    assign o_lanes = r_lanes;

endmodule

// File: hdl/etq_quat.sv
module etq_quat import etq_pkg::*; #(
    parameter int COMP_BITS = COMP_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    output logic                        o_rdy,
    input  t_sc3                        i_sc,
    output logic                        o_vld,
    input  logic                        i_rdy,
    output logic signed [COMP_BITS-1:0] o_quat_w,
    output logic signed [COMP_BITS-1:0] o_quat_x,
    output logic signed [COMP_BITS-1:0] o_quat_y,
    output logic signed [COMP_BITS-1:0] o_quat_z
);

    localparam int SH  = 61 - COMP_BITS;
    localparam int FW  = PROD_W + 1;
    localparam logic signed [FW-1:0] RND = 65'sd1 <<< (SH - 1);
    localparam logic signed [FW-1:0] HI  = (65'sd1 <<< (COMP_BITS - 1)) - 65'sd1;
    localparam logic signed [FW-1:0] LO  = -(65'sd1 <<< (COMP_BITS - 1));

    // round half up to q1.(COMP_BITS-1) and saturate
    function automatic logic signed [COMP_BITS-1:0] finish(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [FW-1:0] r;
        r = (FW'(v) + RND) >>> SH;
        if (r > HI) begin
            r = HI;
        end
        if (r < LO) begin
            r = LO;
        end
        return COMP_BITS'(r);
    endfunction

    logic [3:0] r_vld;
    logic [3:0] rdy;

    // stage 1: pair products
    logic signed [SC_W-1:0] r_cc, r_ss, r_sc, r_cs, r_cz, r_sz;
    // stage 2: triple products
    logic signed [PROD_W-1:0] r_ccc, r_sss, r_scc, r_css, r_csc, r_scs, r_ccs, r_ssc;
    // stage 3: component sums
    logic signed [PROD_W-1:0] r_sw, r_sx, r_sy, r_sz_sum;
    // stage 4: output register
    logic signed [COMP_BITS-1:0] r_qw, r_qx, r_qy, r_qz;

    // ready chain, a stage loads when empty or draining
    assign rdy[3] = !r_vld[3] || i_rdy;
    assign rdy[2] = !r_vld[2] || rdy[3];
    assign rdy[1] = !r_vld[1] || rdy[2];
    assign rdy[0] = !r_vld[0] || rdy[1];
    assign o_rdy  = rdy[0];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_vld;
            end
            if (rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (rdy[2]) begin
                r_vld[2] <= r_vld[1];
            end
            if (rdy[3]) begin
                r_vld[3] <= r_vld[2];
            end
        end
    end

    // pair products of the x and y factors
    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_vld) begin
            r_cc <= pair_mul(i_sc[0].c, i_sc[1].c);
            r_ss <= pair_mul(i_sc[0].s, i_sc[1].s);
            r_sc <= pair_mul(i_sc[0].s, i_sc[1].c);
            r_cs <= pair_mul(i_sc[0].c, i_sc[1].s);
            r_cz <= i_sc[2].c;
            r_sz <= i_sc[2].s;
        end
    end

    // times the z factor
    always_ff @(posedge i_clk) begin
        if (rdy[1] && r_vld[0]) begin
            r_ccc <= r_cc * r_cz;
            r_sss <= r_ss * r_sz;
            r_scc <= r_sc * r_cz;
            r_css <= r_cs * r_sz;
            r_csc <= r_cs * r_cz;
            r_scs <= r_sc * r_sz;
            r_ccs <= r_cc * r_sz;
            r_ssc <= r_ss * r_cz;
        end
    end

    // sums and differences
    always_ff @(posedge i_clk) begin
        if (rdy[2] && r_vld[1]) begin
            r_sw     <= r_ccc + r_sss;
            r_sx     <= r_scc - r_css;
            r_sy     <= r_csc + r_scs;
            r_sz_sum <= r_ccs - r_ssc;
        end
    end

    // rounding and saturation
    always_ff @(posedge i_clk) begin
        if (rdy[3] && r_vld[2]) begin
            r_qw <= finish(r_sw);
            r_qx <= finish(r_sx);
            r_qy <= finish(r_sy);
            r_qz <= finish(r_sz_sum);
        end
    end

    assign o_vld    = r_vld[3];
    assign o_quat_w = r_qw;
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;

endmodule

// File: hdl/euler_to_quaternion.sv
// euler angles to quaternion, fully pipelined
//
// input stream: one beat carries angle_x, angle_y and angle_z, signed binary
// angles where 2^(ANGLE_BITS-1) stands for pi. output stream: one beat per
// input beat with quat_w, quat_x, quat_y, quat_z in signed q1.(COMP_BITS-1),
// +1.0 saturating to the largest positive code.
//
// from input accept to output valid the beat passes 30 cordic stages
// (one rotation step per stage, all three axes side by side) followed by
// pair products, triple products, sums and a rounding/output register.
// one beat per cycle unless stalled; every stage carries its own valid bit.
//
// reset empties the pipeline; no other state exists. when the receiver
// stalls, the result waits in the output register and earlier stages keep
// filling empty slots, so input is refused only once every stage is full.
// nothing is dropped or repeated across a stall.
module euler_to_quaternion import etq_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int COMP_BITS  = COMP_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // angle_x, angle_y, angle_z from bit 0 up, zero padded to bytes
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]       i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z from bit 0 up, zero padded to bytes
    output logic [((4*COMP_BITS+7)/8)*8-1:0]        o_m_axis_tdata
);

    localparam int OUT_W = ((4*COMP_BITS+7)/8)*8;

    logic   stg_vld [CORDIC_STEPS+1];
    logic   stg_rdy [CORDIC_STEPS+1];
    t_lanes stg_lanes [CORDIC_STEPS+1];
    t_sc3   sc;

    logic signed [COMP_BITS-1:0] quat_w, quat_x, quat_y, quat_z;

    // halve each angle, move it to a 32-bit binary angle, seed the rotation
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            logic signed [ANGLE_BITS-1:0] ang;
            logic signed [31:0]           a32;
            ang = i_s_axis_tdata[l*ANGLE_BITS +: ANGLE_BITS];
            a32 = 32'(ang);
            stg_lanes[0][l].x = CORDIC_START;
            stg_lanes[0][l].y = '0;
            stg_lanes[0][l].z = Z_W'((a32 >>> 1) <<< (32 - ANGLE_BITS));
        end
    end

    assign stg_vld[0]      = i_s_axis_tvalid;
    assign o_s_axis_tready = stg_rdy[0];

    // rotation pipeline, one step per stage
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        etq_cordic_stage #(
            .STEP (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (stg_vld[g]),
            .o_rdy   (stg_rdy[g]),
            .i_lanes (stg_lanes[g]),
            .o_vld   (stg_vld[g+1]),
            .i_rdy   (stg_rdy[g+1]),
            .o_lanes (stg_lanes[g+1])
        );
    end

    // cosine and sine of each half angle
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            sc[l].c = SC_W'(stg_lanes[CORDIC_STEPS][l].x);
            sc[l].s = SC_W'(stg_lanes[CORDIC_STEPS][l].y);
        end
    end

    // products, sums and output register
    etq_quat #(
        .COMP_BITS (COMP_BITS)
    ) u_quat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (stg_vld[CORDIC_STEPS]),
        .o_rdy    (stg_rdy[CORDIC_STEPS]),
        .i_sc     (sc),
        .o_vld    (o_m_axis_tvalid),
        .i_rdy    (i_m_axis_tready),
        .o_quat_w (quat_w),
        .o_quat_x (quat_x),
        .o_quat_y (quat_y),
        .o_quat_z (quat_z)
    );

    assign o_m_axis_tdata = OUT_W'({quat_z, quat_y, quat_x, quat_w});

endmodule

// File: tb/sv/euler_to_quaternion_tb.sv
`timescale 1ns / 100ps

module euler_to_quaternion_tb;
    import etq_pkg::*;

    localparam int ANG_W    = ANGLE_BITS_DEF;
    localparam int COMP_W   = COMP_BITS_DEF;
    localparam int IN_W     = ((3*ANG_W+7)/8)*8;
    localparam int OUT_W    = ((4*COMP_W+7)/8)*8;
    localparam int STEPS    = 30;
    localparam int PAIR_SH  = 30;
    localparam int ROUND_SH = 61 - COMP_W;
    localparam longint GAIN_INV = 64'sd652032874;   // 1/K of the cordic, q2.30
    localparam int N_RANDOM = 650;
    localparam int TAIL_CYC = 40;                    // pipeline is 34 deep

    // x in the lowest bits
    typedef struct packed {
        logic signed [ANG_W-1:0] z;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] x;
    } angles_t;

    // w in the lowest bits
    typedef struct packed {
        logic signed [COMP_W-1:0] z;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] w;
    } quat_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tready = 1'b0;
    logic              o_s_axis_tready;
    logic              o_m_axis_tvalid;
    logic [OUT_W-1:0]  o_m_axis_tdata;

    angles_t pending_angles[$];
    quat_t   expected_quats[$];
    int      angles_sent = 0;
    int      quats_checked = 0;
    int      mismatch_cnt = 0;
    int      directed_cnt = 0;
    bit      idle_on;

    euler_to_quaternion dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // arctangent of 2^-i as a 32-bit binary angle
    function automatic longint atan_turn(input int i);
        case (i)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            16: return 10430;
            17: return 5215;
            18: return 2608;
            19: return 1304;
            20: return 652;
            21: return 326;
            22: return 163;
            23: return 81;
            24: return 41;
            25: return 20;
            26: return 10;
            27: return 5;
            28: return 3;
            default: return 1;
        endcase
    endfunction

    // cosine and sine of half the angle, q2.30, rotation-mode cordic
    function automatic void half_angle_trig(input logic signed [ANG_W-1:0] ang,
                                            output longint cos_q, output longint sin_q);
        longint x, y, z, dx, dy;
        int i;
        x = GAIN_INV;
        y = 0;
        // halve with floor, then scale to a 32-bit binary angle
        z = (longint'(ang) >>> 1) * (longint'(1) << (32 - ANG_W));
        for (i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_turn(i);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_turn(i);
            end
        end
        cos_q = x;
        sin_q = y;
    endfunction

    // pair product back to q2.30 with floor, then times the third factor (q.60)
    function automatic longint triple_prod(input longint a, input longint b, input longint c);
        return ((a * b) >>> PAIR_SH) * c;
    endfunction

    // round half up to q1.15 and saturate
    function automatic logic signed [COMP_W-1:0] round_to_comp(input longint v);
        longint r;
        longint hi, lo;
        hi = (longint'(1) << (COMP_W - 1)) - 1;
        lo = -(longint'(1) << (COMP_W - 1));
        r = (v + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return COMP_W'(r);
    endfunction

    function automatic quat_t euler_to_quat(input angles_t a);
        longint cx, sx, cy, sy, cz, sz;
        quat_t q;
        half_angle_trig(a.x, cx, sx);
        half_angle_trig(a.y, cy, sy);
        half_angle_trig(a.z, cz, sz);
        q.w = round_to_comp(triple_prod(cx, cy, cz) + triple_prod(sx, sy, sz));
        q.x = round_to_comp(triple_prod(sx, cy, cz) - triple_prod(cx, sy, sz));
        q.y = round_to_comp(triple_prod(cx, sy, cz) + triple_prod(sx, cy, sz));
        q.z = round_to_comp(triple_prod(cx, cy, sz) - triple_prod(sx, sy, cz));
        return q;
    endfunction

    // mostly uniform, with a share of corner values and small angles
    function automatic logic signed [ANG_W-1:0] pick_angle();
        logic signed [ANG_W-1:0] a;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(7))
                    0: a = ANG_W'(-(1 <<< (ANG_W-1)));
                    1: a = ANG_W'((1 <<< (ANG_W-1)) - 1);
                    2: a = ANG_W'(1 <<< (ANG_W-2));
                    3: a = ANG_W'(-(1 <<< (ANG_W-2)));
                    4: a = ANG_W'(1);
                    5: a = ANG_W'(-1);
                    6: a = '0;
                    default: a = ANG_W'(-(1 <<< (ANG_W-1)) + 1);
                endcase
            end
            1: a = ANG_W'($urandom_range(64)) - ANG_W'(32);
            default: a = ANG_W'($urandom);
        endcase
        return a;
    endfunction

    task automatic queue_angles(input int ax, input int ay, input int az);
        angles_t a;
        a.x = ANG_W'(ax);
        a.y = ANG_W'(ay);
        a.z = ANG_W'(az);
        pending_angles.push_back(a);
    endtask

    // hold the sender until every queued beat is out and every result is back
    task automatic wait_drained();
        while (pending_angles.size() != 0 || s_tvalid) @(negedge i_clk);
        while (expected_quats.size() != 0) @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic signed [COMP_W-1:0] exp_v,
                               input logic signed [COMP_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    // stretch without random stalls in the middle of the random part
    assign idle_on = !(angles_sent >= 300 && angles_sent < 450);

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                expected_quats.push_back(euler_to_quat(angles_t'(s_tdata[3*ANG_W-1:0])));
                angles_sent++;
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (pending_angles.size() != 0 &&
                        !(idle_on && $urandom_range(99) < 27)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_W'(pending_angles.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor and backpressure
    always @(posedge i_clk) begin
        quat_t exp_q, got_q;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                got_q = quat_t'(o_m_axis_tdata[4*COMP_W-1:0]);
                if (expected_quats.size() == 0) begin
                    $error("unexpected output beat: w=%0d x=%0d y=%0d z=%0d",
                           got_q.w, got_q.x, got_q.y, got_q.z);
                    mismatch_cnt++;
                end else begin
                    exp_q = expected_quats.pop_front();
                    check_field("quat_w", exp_q.w, got_q.w);
                    check_field("quat_x", exp_q.x, got_q.x);
                    check_field("quat_y", exp_q.y, got_q.y);
                    check_field("quat_z", exp_q.z, got_q.z);
                    quats_checked++;
                end
            end
            m_tready <= !(idle_on && $urandom_range(99) < 27);
        end
    end

    // stimulus and end of run
    initial begin
        int i;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero, field extremes, quarter turns, odd halving, saturation
        queue_angles(0, 0, 0);
        queue_angles(-32768, 0, 0);
        queue_angles(0, -32768, 0);
        queue_angles(0, 0, -32768);
        queue_angles(32767, 0, 0);
        queue_angles(0, 32767, 0);
        queue_angles(0, 0, 32767);
        queue_angles(16384, 0, 0);
        queue_angles(0, -16384, 0);
        queue_angles(0, 0, 16384);
        queue_angles(1, -1, 1);
        queue_angles(-1, 1, -1);
        queue_angles(3, -3, 32765);
        queue_angles(-32768, -32768, -32768);
        queue_angles(32767, 32767, 32767);
        queue_angles(-32768, 32767, -32768);
        queue_angles(16384, 16384, 16384);
        queue_angles(-16384, 16384, -16384);
        queue_angles(8192, -8192, 24576);
        queue_angles(-21846, 10923, 5461);
        queue_angles(-32767, 1, -32767);
        queue_angles(21845, -21845, 0);
        directed_cnt = pending_angles.size();

        wait_drained();
        @(negedge i_clk);
        for (i = 0; i < N_RANDOM / 2; i++)
            queue_angles(pick_angle(), pick_angle(), pick_angle());

        // sender pauses until the pipeline is empty again
        wait_drained();
        @(negedge i_clk);
        for (i = N_RANDOM / 2; i < N_RANDOM; i++)
            queue_angles(pick_angle(), pick_angle(), pick_angle());

        wait_drained();
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("sent %0d angle triples (%0d directed, %0d random), checked %0d quaternions",
                 angles_sent, directed_cnt, angles_sent - directed_cnt, quats_checked);
        $display("stalls on both sides with a quiet stretch, %0d mismatches", mismatch_cnt);
        if (mismatch_cnt == 0 && expected_quats.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("timeout with %0d results outstanding", expected_quats.size());
        $display("Verification failed");
        $finish;
    end

endmodule
